// ----- rtl/tcw_pkg.sv -----
// Shared constants, codes and types of the text console character writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // Screen geometry.
   localparam int unsigned COLUMNS    = 80;
   localparam int unsigned ROWS       = 25;
   localparam int unsigned CELL_COUNT = ROWS * COLUMNS;

   // Internal widths that follow from the geometry.
   localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
   localparam int unsigned ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
   localparam int unsigned COL_W  = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;

   // Field widths of the channels.
   localparam int unsigned ACTION_W     = 2;
   localparam int unsigned CHAR_W       = 8;
   localparam int unsigned COLOR_W      = 8;
   localparam int unsigned INDEX_W      = 11;
   localparam int unsigned CELL_W       = 16;
   localparam int unsigned CURSOR_ROW_W = 5;
   localparam int unsigned CURSOR_COL_W = 7;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Character codes with special meaning.
   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;

   // One access to the cell store: one write port and one read port.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_cmd_type;

   // Finished item handed to the result register.
   typedef struct packed {
      logic             load;
      logic             read_hit;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } done_type;

endpackage

`default_nettype wire

// ----- rtl/tcw_cell_ram.sv -----
// Screen cell store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram (
   input  wire logic                        clock,
   input  wire tcw_pkg::ram_cmd_type        ram_cmd,
   output      logic [tcw_pkg::CELL_W-1:0]  ram_rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] cells_mem [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_cmd.wr_en) begin
         cells_mem[ram_cmd.wr_addr] <= ram_cmd.wr_data;
      end
      if (ram_cmd.rd_en) begin
         rd_data_ff <= cells_mem[ram_cmd.rd_addr];
      end
   end

   assign ram_rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/tcw_sequencer.sv -----
// Control sequencer: cursor, item decode and the sweeps over the cell store.
`timescale 1ns / 1ps
`default_nettype none

module tcw_sequencer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [tcw_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [tcw_pkg::COLOR_W-1:0]   req_color,
   input  wire logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
   input  wire logic [tcw_pkg::CELL_W-1:0]    ram_rd_data,
   input  wire logic                          out_free,
   output      tcw_pkg::ram_cmd_type          ram_cmd,
   output      tcw_pkg::done_type             done
);
   import tcw_pkg::*;

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCROLL = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   localparam logic [ADDR_W-1:0] ADDR_LAST   = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELL_COUNT - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ROW  = ADDR_W'(CELL_COUNT - COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
   localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              read_hit_ff, read_hit_in;
   logic [CELL_W-1:0] fill_data_ff, fill_data_in;

   logic [ADDR_W-1:0] cursor_addr;
   logic              index_ok;
   logic              wrap;

   assign cursor_addr = ADDR_W'(int'(row_ff) * COLUMNS + int'(col_ff));
   assign index_ok    = int'(req_cell_index) < CELL_COUNT;
   assign wrap        = (req_char_code == CHAR_NEWLINE) || (col_ff == COL_LAST);
   assign req_stall   = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      read_hit_in  = read_hit_ff;
      fill_data_in = fill_data_ff;
      ram_cmd      = '0;
      done         = '0;
      done.read_hit = read_hit_ff;
      done.row      = row_ff;
      done.col      = col_ff;

      unique case (state_ff)
         S_INIT: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = cnt_ff;
            ram_cmd.wr_data = '0;
            if (cnt_ff == ADDR_LAST) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               read_hit_in  = 1'b0;
               fill_data_in = {req_color, CHAR_BLANK};
               cnt_in       = '0;
               pend_in      = 1'b0;
               state_in     = S_DONE;
               unique case (req_action)
                  ACT_PUT: begin
                     if (req_char_code != CHAR_RETURN) begin
                        if (req_char_code != CHAR_NEWLINE) begin
                           ram_cmd.wr_en   = 1'b1;
                           ram_cmd.wr_addr = cursor_addr;
                           ram_cmd.wr_data = {req_color, req_char_code};
                        end
                        if (!wrap) begin
                           col_in = col_ff + 1'b1;
                        end else begin
                           col_in = '0;
                           if (row_ff == ROW_LAST) begin
                              state_in = S_SCROLL;
                           end else begin
                              row_in = row_ff + 1'b1;
                           end
                        end
                     end
                  end
                  ACT_READ: begin
                     if (index_ok) begin
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = ADDR_W'(req_cell_index);
                        read_hit_in     = 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     state_in = S_FILL;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCROLL: begin
            // Read one row ahead and write the word read last cycle.
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = cnt_ff + ROW_STRIDE;
            ram_cmd.wr_en   = pend_ff;
            ram_cmd.wr_addr = pend_addr_ff;
            ram_cmd.wr_data = ram_rd_data;
            pend_in         = 1'b1;
            pend_addr_in    = cnt_ff;
            if (cnt_ff == SCROLL_LAST) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = pend_addr_ff;
            ram_cmd.wr_data = ram_rd_data;
            pend_in         = 1'b0;
            cnt_in          = BOTTOM_ROW;
            state_in        = S_FILL;
         end
         S_FILL: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = cnt_ff;
            ram_cmd.wr_data = fill_data_ff;
            if (cnt_ff == ADDR_LAST) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               done.load = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         cnt_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         pend_ff     <= 1'b0;
         read_hit_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         pend_ff     <= pend_in;
         read_hit_ff <= read_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      fill_data_ff <= fill_data_in;
   end

`ifndef SYNTH
   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      (int'(row_ff) < ROWS) && (int'(col_ff) < COLUMNS))
      else $error("cursor left the screen");

   a_idle_no_stray_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_valid) |-> !ram_cmd.wr_en)
      else $error("cell store written with no item");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      done.load |-> out_free)
      else $error("result loaded over an untaken word");

   a_scroll_read_ahead: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL && pend_ff) |->
         (ram_cmd.rd_addr == pend_addr_ff + ADDR_W'(COLUMNS + 1)))
      else $error("scroll read does not lead its write by one row");
`endif

endmodule

`default_nettype wire

// ----- rtl/text_console_char_writer_unit.sv -----
// Top level of the text console character writer: store, sequencer, result register.
//
// The block keeps a ROWS x COLUMNS screen of 16-bit cells (character in the low
// byte, color in the high byte) and a cursor. Each word on the req_ channel is
// one item: put a character, read a cell, or clear the screen. Each item yields
// exactly one word on the rsp_ channel carrying the read data (zero except for
// an in-range read) and the cursor after the item.
// An item is taken when req_valid is high and req_stall is low; a result is
// taken when rsp_valid is high and rsp_stall is low.
// A put that does not scroll, a read or the unused action is decoded in S_IDLE,
// which touches the cell store; S_DONE loads the result once out_free is high.
// A put that moves past the last row scrolls: the store is copied up one row
// at one cell per cycle through its single read and write ports, and the bottom
// row is then filled. A clear fills every cell. req_stall is high throughout.
// After reset, a clearing pass writes zero to every cell with req_stall high;
// the cursor starts at the home position.
// The result sits in an output register. A new item is taken while an earlier
// result still waits there; the new item's result waits in the sequencer until
// the receiver takes the old word, so nothing is lost while rsp_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [tcw_pkg::ACTION_W-1:0]        req_action,
   input  wire logic [tcw_pkg::CHAR_W-1:0]          req_char_code,
   input  wire logic [tcw_pkg::COLOR_W-1:0]         req_color,
   input  wire logic [tcw_pkg::INDEX_W-1:0]         req_cell_index,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [tcw_pkg::CELL_W-1:0]          rsp_read_data,
   output      logic [tcw_pkg::CURSOR_ROW_W-1:0]    rsp_cursor_row,
   output      logic [tcw_pkg::CURSOR_COL_W-1:0]    rsp_cursor_col
);
   import tcw_pkg::*;

   ram_cmd_type       ram_cmd;
   done_type          done;
   logic [CELL_W-1:0] ram_rd_data;
   logic              out_free;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]       rsp_read_data_ff, rsp_read_data_in;
   logic [CURSOR_ROW_W-1:0] rsp_cursor_row_ff, rsp_cursor_row_in;
   logic [CURSOR_COL_W-1:0] rsp_cursor_col_ff, rsp_cursor_col_in;

   tcw_cell_ram u_cell_ram (
      .clock       (clock),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data)
   );

   tcw_sequencer u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_color      (req_color),
      .req_cell_index (req_cell_index),
      .ram_rd_data    (ram_rd_data),
      .out_free       (out_free),
      .ram_cmd        (ram_cmd),
      .done           (done)
   );

   // The register can take a new word when it is empty or being emptied.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_read_data_in  = rsp_read_data_ff;
      rsp_cursor_row_in = rsp_cursor_row_ff;
      rsp_cursor_col_in = rsp_cursor_col_ff;
      if (done.load) begin
         rsp_valid_in      = 1'b1;
         // The read data holds in the store's output register until used.
         rsp_read_data_in  = done.read_hit ? ram_rd_data : '0;
         rsp_cursor_row_in = CURSOR_ROW_W'(done.row);
         rsp_cursor_col_in = CURSOR_COL_W'(done.col);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_data_ff  <= rsp_read_data_in;
      rsp_cursor_row_ff <= rsp_cursor_row_in;
      rsp_cursor_col_ff <= rsp_cursor_col_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_cursor_row = rsp_cursor_row_ff;
   assign rsp_cursor_col = rsp_cursor_col_ff;

endmodule

`default_nettype wire
